@@ src/bpcd_pkg.sv @@
package bpcd_pkg;

	localparam int EXT_W      = 24;
	localparam int VF_W       = 20;
	localparam int DIST_W     = 26;
	localparam int TOL_W      = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;
	// Clamped fraction holds 1.0 at the widest fraction format.
	localparam int FV_W       = 25;
	localparam int QDEPTH     = 2;

	// Shared multiplier: one chunk of the wide operand per cycle.
	localparam int CW         = 26;
	localparam int MY_W       = 28;
	localparam int NCH_MAX    = 4;
	localparam int NCH_W      = 3;
	localparam int IDX_W      = 2;
	localparam int MX_W       = CW * NCH_MAX;
	localparam int MP_W       = MX_W + MY_W;

	localparam int AF_W       = 50;
	localparam int SQ_V_W     = 50;
	localparam int SUM_W      = 81;
	localparam int CMP_W      = SUM_W + 25;

	typedef enum logic [1:0] {
		KIND_LINE = 2'd0,
		KIND_SLAB = 2'd1,
		KIND_CUBE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [EXT_W-1:0] a;
		logic [EXT_W-1:0] b;
		logic [EXT_W-1:0] c;
		logic [FV_W-1:0]  f;
		kind_t            kind;
	} job_t;

	typedef struct packed {
		logic [DIST_W-1:0] cut_len;
		kind_t             kind;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [NCH_W-1:0] nch;
		logic [MX_W-1:0]  x;
		logic [MY_W-1:0]  y;
	} mul_req_t;

	typedef struct packed {
		logic            done;
		logic [MP_W-1:0] p;
	} mul_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_SLAB_SEL,
		S_SQRT,
		S_SLAB_FIN,
		S_MID,
		S_TERM,
		S_CMP,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_LINE,
		OP_AF,
		OP_VB,
		OP_AB,
		OP_ABC,
		OP_TGT,
		OP_SQ,
		OP_CU
	} op_t;

endpackage

@@ src/bpcd_fifo.sv @@
module bpcd_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ src/bpcd_mul.sv @@
module bpcd_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  bpcd_pkg::mul_req_t req,
	output bpcd_pkg::mul_rsp_t rsp
);
	logic [bpcd_pkg::MX_W-1:0]  x_q;
	logic [bpcd_pkg::MY_W-1:0]  y_q;
	logic [bpcd_pkg::IDX_W-1:0] idx_q;
	logic                       busy_q;
	logic                       done_q;
	logic [bpcd_pkg::MP_W-1:0]  acc_q;
	logic [bpcd_pkg::CW-1:0]    chunk;
	logic [bpcd_pkg::CW+bpcd_pkg::MY_W-1:0] part;

	// Chunks are taken from the most significant one down, so the
	// accumulator only ever shifts by one chunk width.
	assign chunk = x_q[idx_q*bpcd_pkg::CW +: bpcd_pkg::CW];
	assign part  = chunk * y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && idx_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.x;
			y_q   <= req.y;
			idx_q <= bpcd_pkg::IDX_W'(req.nch - 1'b1);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << bpcd_pkg::CW) + bpcd_pkg::MP_W'(part);
			idx_q <= idx_q - 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule

@@ src/bpcd_front.sv @@
module bpcd_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tol_we,
	input  logic [bpcd_pkg::TOL_W-1:0]   tol_data,
	input  logic                         push,
	output logic                         full,
	input  logic [bpcd_pkg::EXT_W-1:0]   ext0,
	input  logic [bpcd_pkg::EXT_W-1:0]   ext1,
	input  logic [bpcd_pkg::EXT_W-1:0]   ext2,
	input  logic [bpcd_pkg::VF_W-1:0]    vf,
	output logic                         job_wr,
	output bpcd_pkg::job_t               job,
	input  logic                         job_full
);
	localparam int EW = bpcd_pkg::EXT_W;
	localparam int FW = bpcd_pkg::FV_W;
	localparam int PW = bpcd_pkg::TOL_W + EW;
	localparam logic [FW:0] ONE_U = (FW + 1)'(1) << FRAC_BITS;

	logic [bpcd_pkg::TOL_W-1:0] tol_q;
	logic          v_s1, v_s2;
	logic [EW-1:0] a_s1, b_s1, c_s1;
	logic [FW-1:0] f_s1;
	bpcd_pkg::job_t job_s2;
	logic          adv1, adv2;
	logic [EW-1:0] sa, sb, sc, t0, t1, t2;
	logic [FW:0]   v_ext;
	logic [FW-1:0] f_cl;
	logic [PW-1:0] tol_a, tol_b;
	bpcd_pkg::kind_t kind_c;

	assign adv2 = !v_s2 || !job_full;
	assign adv1 = !v_s1 || adv2;
	assign full = !adv1;
	assign job_wr = v_s2;
	assign job = job_s2;

	always_comb begin
		t0 = ext0;
		t1 = ext1;
		t2 = ext2;
		if (t0 < t1) begin
			sa = t1; t1 = t0; t0 = sa;
		end
		if (t0 < t2) begin
			sa = t2; t2 = t0; t0 = sa;
		end
		if (t1 < t2) begin
			sa = t2; t2 = t1; t1 = sa;
		end
		sa = t0;
		sb = t1;
		sc = t2;
	end

	always_comb begin
		v_ext = {{(FW + 1 - bpcd_pkg::VF_W){vf[bpcd_pkg::VF_W-1]}}, vf};
		if (vf[bpcd_pkg::VF_W-1]) begin
			f_cl = '0;
		end else if (v_ext > ONE_U) begin
			f_cl = FW'(ONE_U);
		end else begin
			f_cl = FW'(v_ext);
		end
	end

	always_comb begin
		tol_a = tol_q * a_s1;
		tol_b = tol_q * b_s1;
		if ({b_s1, 16'b0} <= tol_a) begin
			kind_c = bpcd_pkg::KIND_LINE;
		end else if ({c_s1, 16'b0} <= tol_b) begin
			kind_c = bpcd_pkg::KIND_SLAB;
		end else begin
			kind_c = bpcd_pkg::KIND_CUBE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= bpcd_pkg::TOL_RESET;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (tol_we) begin
				tol_q <= tol_data;
			end
			if (adv1) begin
				v_s1 <= push;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && push) begin
			a_s1 <= sa;
			b_s1 <= sb;
			c_s1 <= sc;
			f_s1 <= f_cl;
		end
		if (adv2 && v_s1) begin
			job_s2.a    <= a_s1;
			job_s2.b    <= b_s1;
			job_s2.c    <= c_s1;
			job_s2.f    <= f_s1;
			job_s2.kind <= kind_c;
		end
	end

endmodule

@@ src/bpcd_back.sv @@
module bpcd_back #(
	parameter int BISECT_STEPS = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpcd_pkg::job_t     job,
	input  logic               job_empty,
	output logic               job_pop,
	output bpcd_pkg::res_t     res,
	input  logic               res_full,
	output logic               res_push,
	output bpcd_pkg::mul_req_t mreq,
	input  bpcd_pkg::mul_rsp_t mrsp
);
	localparam int EW = bpcd_pkg::EXT_W;
	localparam int DW = bpcd_pkg::DIST_W;
	localparam int AW = bpcd_pkg::AF_W;
	localparam int VW = bpcd_pkg::SQ_V_W;
	localparam int SW = bpcd_pkg::SUM_W;
	localparam int CPW = bpcd_pkg::CMP_W;
	localparam int XW = bpcd_pkg::MX_W;
	localparam int YW = bpcd_pkg::MY_W;
	localparam int NW = bpcd_pkg::NCH_W;
	localparam int KW = (BISECT_STEPS > 1) ? $clog2(BISECT_STEPS) : 1;
	localparam logic [2:0] J_POS_LAST = 3'd3;
	localparam logic [2:0] J_LAST     = 3'd6;

	bpcd_pkg::state_t state_q, state_d;
	bpcd_pkg::op_t    op_q, op_d;
	logic [EW-1:0] a_q, a_d, b_q, b_d, c_q, c_d;
	logic [bpcd_pkg::FV_W-1:0] f_q, f_d;
	bpcd_pkg::kind_t kind_q, kind_d;
	logic [AW-1:0] two_af_q, two_af_d;
	logic          side_q, side_d;
	logic [VW-1:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d;
	logic [DW-1:0] lo_q, lo_d, hi_q, hi_d, m_q, m_d, t_q, t_d, d_q, d_d;
	logic [2:0]    j_q, j_d;
	logic [KW-1:0] k_q, k_d;
	logic [SW-1:0] pos_q, pos_d, neg_q, neg_d;
	logic [CPW-1:0] tgt_q, tgt_d;

	logic [AW-1:0] b_one, two_aw;
	logic [AW:0]   mid_lin;
	logic [DW:0]   mid_sum;
	logic [DW-1:0] shift_s;
	logic [VW-1:0] trial;
	logic [CPW-1:0] lhs, rhs;
	logic [YW-1:0] f_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpcd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		a_q      <= a_d;
		b_q      <= b_d;
		c_q      <= c_d;
		f_q      <= f_d;
		kind_q   <= kind_d;
		two_af_q <= two_af_d;
		side_q   <= side_d;
		rem_q    <= rem_d;
		root_q   <= root_d;
		bit_q    <= bit_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		m_q      <= m_d;
		t_q      <= t_d;
		d_q      <= d_d;
		j_q      <= j_d;
		k_q      <= k_d;
		pos_q    <= pos_d;
		neg_q    <= neg_d;
		tgt_q    <= tgt_d;
	end

	assign res.cut_len = d_q;
	assign res.kind    = kind_q;

	always_comb begin
		b_one   = AW'(b_q) << FRAC_BITS;
		two_aw  = (AW'(a_q) << (FRAC_BITS + 1)) - two_af_q;
		mid_lin = (AW + 1)'(b_one) + (AW + 1)'(two_af_q);
		mid_sum = (DW + 1)'(lo_q) + (DW + 1)'(hi_q);
		trial   = root_q + bit_q;
		lhs     = CPW'(pos_q) << FRAC_BITS;
		rhs     = (CPW'(neg_q) << FRAC_BITS) + tgt_q;
		f_y     = YW'(f_q);
		case (j_q)
			3'd1:    shift_s = DW'(b_q) + DW'(c_q);
			3'd2:    shift_s = DW'(a_q) + DW'(c_q);
			3'd3:    shift_s = DW'(a_q) + DW'(b_q);
			3'd4:    shift_s = DW'(a_q);
			3'd5:    shift_s = DW'(b_q);
			3'd6:    shift_s = DW'(c_q);
			default: shift_s = '0;
		endcase

		state_d  = state_q;
		op_d     = op_q;
		a_d      = a_q;
		b_d      = b_q;
		c_d      = c_q;
		f_d      = f_q;
		kind_d   = kind_q;
		two_af_d = two_af_q;
		side_d   = side_q;
		rem_d    = rem_q;
		root_d   = root_q;
		bit_d    = bit_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		m_d      = m_q;
		t_d      = t_q;
		d_d      = d_q;
		j_d      = j_q;
		k_d      = k_q;
		pos_d    = pos_q;
		neg_d    = neg_q;
		tgt_d    = tgt_q;
		job_pop  = 1'b0;
		res_push = 1'b0;
		mreq     = '0;

		case (state_q)
			bpcd_pkg::S_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					a_d     = job.a;
					b_d     = job.b;
					c_d     = job.c;
					f_d     = job.f;
					kind_d  = job.kind;
					state_d = bpcd_pkg::S_START;
				end
			end
			bpcd_pkg::S_START: begin
				mreq.start = 1'b1;
				mreq.nch   = NW'(1);
				mreq.x     = XW'(a_q);
				state_d    = bpcd_pkg::S_WAIT;
				case (kind_q)
					bpcd_pkg::KIND_LINE: begin
						mreq.y = f_y;
						op_d   = bpcd_pkg::OP_LINE;
					end
					bpcd_pkg::KIND_SLAB: begin
						mreq.y = f_y;
						op_d   = bpcd_pkg::OP_AF;
					end
					default: begin
						mreq.y = YW'(b_q);
						op_d   = bpcd_pkg::OP_AB;
						lo_d   = '0;
						hi_d   = DW'(a_q) + DW'(b_q) + DW'(c_q);
						k_d    = '0;
					end
				endcase
			end
			bpcd_pkg::S_WAIT: begin
				if (mrsp.done) begin
					case (op_q)
						bpcd_pkg::OP_LINE: begin
							d_d = DW'(mrsp.p >> FRAC_BITS) + DW'(b_q) + DW'(c_q);
							state_d = bpcd_pkg::S_DONE;
						end
						bpcd_pkg::OP_AF: begin
							two_af_d = AW'(mrsp.p) << 1;
							state_d  = bpcd_pkg::S_SLAB_SEL;
						end
						bpcd_pkg::OP_VB: begin
							rem_d   = VW'(mrsp.p >> FRAC_BITS);
							root_d  = '0;
							bit_d   = VW'(1) << (VW - 2);
							state_d = bpcd_pkg::S_SQRT;
						end
						bpcd_pkg::OP_AB: begin
							mreq.start = 1'b1;
							mreq.nch   = NW'(2);
							mreq.x     = XW'(mrsp.p);
							mreq.y     = YW'(c_q);
							op_d       = bpcd_pkg::OP_ABC;
						end
						bpcd_pkg::OP_ABC: begin
							mreq.start = 1'b1;
							mreq.nch   = NW'(3);
							mreq.x     = XW'(mrsp.p);
							mreq.y     = (f_y << 2) + (f_y << 1);
							op_d       = bpcd_pkg::OP_TGT;
						end
						bpcd_pkg::OP_TGT: begin
							tgt_d   = CPW'(mrsp.p);
							state_d = bpcd_pkg::S_MID;
						end
						bpcd_pkg::OP_SQ: begin
							mreq.start = 1'b1;
							mreq.nch   = NW'(2);
							mreq.x     = XW'(mrsp.p);
							mreq.y     = YW'(t_q);
							op_d       = bpcd_pkg::OP_CU;
						end
						default: begin
							if (j_q <= J_POS_LAST) begin
								pos_d = pos_q + SW'(mrsp.p);
							end else begin
								neg_d = neg_q + SW'(mrsp.p);
							end
							if (j_q == J_LAST) begin
								state_d = bpcd_pkg::S_CMP;
							end else begin
								j_d     = j_q + 1'b1;
								state_d = bpcd_pkg::S_TERM;
							end
						end
					endcase
				end
			end
			bpcd_pkg::S_SLAB_SEL: begin
				if (two_af_q <= b_one) begin
					side_d     = 1'b0;
					mreq.start = 1'b1;
					mreq.nch   = NW'(2);
					mreq.x     = XW'(two_af_q);
					mreq.y     = YW'(b_q);
					op_d       = bpcd_pkg::OP_VB;
					state_d    = bpcd_pkg::S_WAIT;
				end else if (two_aw >= b_one) begin
					d_d     = DW'(mid_lin >> (FRAC_BITS + 1)) + DW'(c_q);
					state_d = bpcd_pkg::S_DONE;
				end else begin
					side_d     = 1'b1;
					mreq.start = 1'b1;
					mreq.nch   = NW'(2);
					mreq.x     = XW'(two_aw);
					mreq.y     = YW'(b_q);
					op_d       = bpcd_pkg::OP_VB;
					state_d    = bpcd_pkg::S_WAIT;
				end
			end
			bpcd_pkg::S_SQRT: begin
				// One result bit per cycle, restoring square root.
				if (rem_q >= trial) begin
					rem_d  = rem_q - trial;
					root_d = (root_q >> 1) + bit_q;
				end else begin
					root_d = root_q >> 1;
				end
				bit_d = bit_q >> 2;
				if (bit_q[0]) begin
					state_d = bpcd_pkg::S_SLAB_FIN;
				end
			end
			bpcd_pkg::S_SLAB_FIN: begin
				if (side_q) begin
					d_d = DW'(a_q) + DW'(b_q) - DW'(root_q) + DW'(c_q);
				end else begin
					d_d = DW'(root_q) + DW'(c_q);
				end
				state_d = bpcd_pkg::S_DONE;
			end
			bpcd_pkg::S_MID: begin
				m_d     = DW'(mid_sum >> 1);
				pos_d   = '0;
				neg_d   = '0;
				j_d     = '0;
				state_d = bpcd_pkg::S_TERM;
			end
			bpcd_pkg::S_TERM: begin
				// A corner at or beyond the plane adds nothing to the volume.
				if (m_q > shift_s) begin
					t_d        = m_q - shift_s;
					mreq.start = 1'b1;
					mreq.nch   = NW'(1);
					mreq.x     = XW'(m_q - shift_s);
					mreq.y     = YW'(m_q - shift_s);
					op_d       = bpcd_pkg::OP_SQ;
					state_d    = bpcd_pkg::S_WAIT;
				end else if (j_q == J_LAST) begin
					state_d = bpcd_pkg::S_CMP;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			bpcd_pkg::S_CMP: begin
				if (lhs > rhs) begin
					hi_d = m_q;
				end else begin
					lo_d = m_q;
				end
				if (k_q == KW'(BISECT_STEPS - 1)) begin
					d_d     = m_q;
					state_d = bpcd_pkg::S_DONE;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = bpcd_pkg::S_MID;
				end
			end
			bpcd_pkg::S_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = bpcd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpcd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ src/box_plane_cut_distance.sv @@
// From an accepted word to its result: the front end registers it in stages s1
// and s2, then the back end runs one multiply (line), up to two multiplies and a
// square root (slab), or BISECT_STEPS bisection steps with two multiplies per
// nonzero truncated cube, at most 7 per step (cube), all on one shared 26x28 multiplier.
// The back end takes one word at a time; two-entry queues decouple it from both
// ports. Reset clears the queues and control and sets the tolerance to 66.
module box_plane_cut_distance #(
	parameter int BISECT_STEPS = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        degenerate_tolerance_we,
	input  logic [15:0] degenerate_tolerance,
	input  logic        push,
	output logic        full,
	input  logic [23:0] extent_first,
	input  logic [23:0] extent_second,
	input  logic [23:0] extent_third,
	input  logic signed [19:0] volume_fraction,
	output logic        empty,
	input  logic        pop,
	output logic [25:0] cut_distance,
	output logic [1:0]  case_kind
);
	localparam int JW = $bits(bpcd_pkg::job_t);
	localparam int RW = $bits(bpcd_pkg::res_t);

	bpcd_pkg::job_t     job_in, job_out;
	bpcd_pkg::res_t     res_in, res_out;
	bpcd_pkg::mul_req_t mreq;
	bpcd_pkg::mul_rsp_t mrsp;
	logic job_wr, job_full, job_empty, job_pop;
	logic res_push, res_full;
	logic [JW-1:0] job_rdata;
	logic [RW-1:0] res_rdata;

	bpcd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tol_we   (degenerate_tolerance_we),
		.tol_data (degenerate_tolerance),
		.push     (push),
		.full     (full),
		.ext0     (extent_first),
		.ext1     (extent_second),
		.ext2     (extent_third),
		.vf       (volume_fraction),
		.job_wr   (job_wr),
		.job      (job_in),
		.job_full (job_full)
	);

	bpcd_fifo #(.W(JW), .DEPTH(bpcd_pkg::QDEPTH)) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (job_wr),
		.wdata (job_in),
		.full  (job_full),
		.rd    (job_pop),
		.rdata (job_rdata),
		.empty (job_empty)
	);

	assign job_out = bpcd_pkg::job_t'(job_rdata);

	bpcd_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rsp   (mrsp)
	);

	bpcd_back #(.BISECT_STEPS(BISECT_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job_out),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.res      (res_in),
		.res_full (res_full),
		.res_push (res_push),
		.mreq     (mreq),
		.mrsp     (mrsp)
	);

	bpcd_fifo #(.W(RW), .DEPTH(bpcd_pkg::QDEPTH)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res_in),
		.full  (res_full),
		.rd    (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_out      = bpcd_pkg::res_t'(res_rdata);
	assign cut_distance = res_out.cut_len;
	assign case_kind    = res_out.kind;

endmodule

@@ tb/sv/tb_box_plane_cut_distance.sv @@
`timescale 1ns / 1ps

module tb_box_plane_cut_distance;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [63:0] UNIT = 64'd65536;

	typedef struct {
		logic [25:0]     cut_len;
		bpcd_pkg::kind_t kind;
	} cut_t;

	class cut_scoreboard;
		cut_t        waiting[$];
		logic [63:0] tol;
		int          errors;

		function new();
			tol = 64'(bpcd_pkg::TOL_RESET);
			errors = 0;
		endfunction

		function logic [63:0] root_floor(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] bval;
			res = 0;
			bval = 64'h4000_0000_0000_0000;
			while (bval > v) bval >>= 2;
			while (bval != 0) begin
				if (v >= res + bval) begin
					v -= res + bval;
					res = (res >> 1) + bval;
				end else begin
					res >>= 1;
				end
				bval >>= 2;
			end
			return res;
		endfunction

		function logic [63:0] scaled_product(logic [63:0] x, logic [63:0] y);
			logic [127:0] p;
			p = 128'(x);
			p = p * y;
			return 64'(p >> 16);
		endfunction

		function logic [127:0] cube_over(logic [63:0] d, logic [63:0] s);
			logic [127:0] t;
			if (d <= s) return 0;
			t = 128'(d - s);
			return t * t * t;
		endfunction

		function logic [63:0] slab_length(logic [63:0] f, logic [63:0] a, logic [63:0] b);
			logic [63:0] two_af, b_one, two_aw;
			two_af = 2 * a * f;
			b_one = b * UNIT;
			two_aw = 2 * a * (UNIT - f);
			if (two_af <= b_one) return root_floor(scaled_product(two_af, b));
			if (two_aw >= b_one) return (b_one + two_af) >> 17;
			return a + b - root_floor(scaled_product(two_aw, b));
		endfunction

		function logic [63:0] bisect_length(logic [63:0] f, logic [63:0] a,
				logic [63:0] b, logic [63:0] c);
			logic [63:0] lo, hi, m;
			logic [127:0] target, pos, neg;
			lo = 0;
			hi = a + b + c;
			m = 0;
			target = 128'(a);
			target = target * b * c * 6 * f;
			for (int k = 0; k < 32; k++) begin
				m = (lo + hi) >> 1;
				pos = cube_over(m, 0) + cube_over(m, b + c) + cube_over(m, a + c)
					+ cube_over(m, a + b);
				neg = cube_over(m, a) + cube_over(m, b) + cube_over(m, c);
				pos = pos << 16;
				neg = (neg << 16) + target;
				if (pos > neg) hi = m;
				else lo = m;
			end
			return m;
		endfunction

		function void note_word(logic [23:0] e0, logic [23:0] e1, logic [23:0] e2,
				logic signed [19:0] vf);
			logic [63:0] a, b, c, t, f, d;
			int v;
			cut_t r;
			a = 64'(e0);
			b = 64'(e1);
			c = 64'(e2);
			v = int'(vf);
			if (v < 0) f = 0;
			else if (v > 65536) f = UNIT;
			else f = 64'(v);
			if (a < b) begin t = a; a = b; b = t; end
			if (a < c) begin t = a; a = c; c = t; end
			if (b < c) begin t = b; b = c; c = t; end
			if ((b << 16) <= tol * a) begin
				r.kind = bpcd_pkg::KIND_LINE;
				d = ((f * a) >> 16) + b + c;
			end else if ((c << 16) <= tol * b) begin
				r.kind = bpcd_pkg::KIND_SLAB;
				d = slab_length(f, a, b) + c;
			end else begin
				r.kind = bpcd_pkg::KIND_CUBE;
				d = bisect_length(f, a, b, c);
			end
			r.cut_len = d[25:0];
			waiting.push_back(r);
		endfunction

		function void check_word(logic [25:0] cut, logic [1:0] kind);
			cut_t e;
			if (waiting.size() == 0) begin
				$display("%0t: unexpected word cut_distance=%0d kind=%0d", $time, cut, kind);
				errors++;
				return;
			end
			e = waiting.pop_front();
			if (cut !== e.cut_len) begin
				$display("%0t: cut_distance expected %0d actual %0d", $time, e.cut_len, cut);
				errors++;
			end
			if (kind !== e.kind) begin
				$display("%0t: case_kind expected %0d actual %0d", $time, e.kind, kind);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        degenerate_tolerance_we;
	logic [15:0] degenerate_tolerance;
	logic        push;
	logic        full;
	logic [23:0] extent_first, extent_second, extent_third;
	logic signed [19:0] volume_fraction;
	logic        empty;
	logic        pop;
	logic [25:0] cut_distance;
	logic [1:0]  case_kind;

	cut_scoreboard sb;
	int tx_idle, rx_idle, quiet;

	box_plane_cut_distance dut (
		.clk(clk), .arst_n(arst_n),
		.degenerate_tolerance_we(degenerate_tolerance_we),
		.degenerate_tolerance(degenerate_tolerance),
		.push(push), .full(full),
		.extent_first(extent_first), .extent_second(extent_second),
		.extent_third(extent_third), .volume_fraction(volume_fraction),
		.empty(empty), .pop(pop),
		.cut_distance(cut_distance), .case_kind(case_kind)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver and watchdog share the sampled handshake values of each edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) sb.check_word(cut_distance, case_kind);
			if ((pop && !empty) || (push && !full)) quiet = 0;
			else quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
		pop <= ($urandom_range(99) >= rx_idle);
	end

	task automatic send_word(logic [23:0] e0, logic [23:0] e1, logic [23:0] e2,
			logic signed [19:0] vf);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		extent_first <= e0;
		extent_second <= e1;
		extent_third <= e2;
		volume_fraction <= vf;
		do @(posedge clk); while (full);
		sb.note_word(e0, e1, e2, vf);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.waiting.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [15:0] v);
		degenerate_tolerance_we <= 1'b1;
		degenerate_tolerance <= v;
		@(posedge clk);
		degenerate_tolerance_we <= 1'b0;
		sb.tol = 64'(v);
	endtask

	task automatic send_random();
		logic [23:0] x, y, z, t;
		logic signed [19:0] vf;
		int shape;
		shape = $urandom_range(5);
		x = 24'($urandom);
		y = 24'($urandom);
		z = 24'($urandom);
		case (shape)
			1: begin
				x = 24'($urandom_range(24'h1000, 24'h40000));
				y = 24'($urandom_range(24'h1000, 24'h40000));
				z = 24'($urandom_range(24'h1000, 24'h40000));
			end
			2: begin
				y = 24'($urandom_range(0, 3));
				z = (shape == 2 && $urandom_range(1)) ? 24'd0 : 24'($urandom_range(0, 3));
			end
			3: begin
				y = x >> $urandom_range(0, 4);
				z = 24'($urandom_range(0, 8));
			end
			4: begin
				y = x;
				z = $urandom_range(1) ? x : 24'd0;
			end
			default: ;
		endcase
		// Present the extents in a random order.
		if ($urandom_range(1)) begin t = x; x = z; z = t; end
		if ($urandom_range(1)) begin t = x; x = y; y = t; end
		case ($urandom_range(9))
			0: vf = 20'($urandom);
			1: vf = $urandom_range(1) ? 20'sd65536 : 20'sd0;
			default: vf = 20'($urandom_range(0, 65536));
		endcase
		send_word(x, y, z, vf);
	endtask

	initial begin
		logic [15:0] tol_plan[6];
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		degenerate_tolerance_we = 1'b0;
		degenerate_tolerance = '0;
		extent_first = '0;
		extent_second = '0;
		extent_third = '0;
		volume_fraction = '0;
		tx_idle = 10;
		rx_idle = 65;
		quiet = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(0, 0, 0, 20'sd32768);
		send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'sd0);
		send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'sd65536);
		send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'sd32768);
		send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'sh7FFFF);
		send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, -20'sd524288);
		send_word(0, 24'hFFFFFF, 0, 20'sd32768);
		send_word(24'hFFFFFF, 0, 0, 20'sd65536);
		send_word(24'h10000, 24'h8000, 0, 20'sd6554);
		send_word(0, 24'h10000, 24'h8000, 20'sd32768);
		send_word(24'h8000, 0, 24'h10000, 20'sd58982);
		send_word(24'h10000, 24'h8000, 0, -20'sd1000);
		send_word(24'h10000, 24'h8000, 0, 20'sd200000);
		send_word(24'h10000, 24'h10000, 24'h10000, 20'sd0);
		send_word(24'h10000, 24'h10000, 24'h10000, 20'sd32768);
		send_word(24'h10000, 24'h10000, 24'h10000, 20'sd65536);
		send_word(24'h30000, 24'h10000, 24'h20000, 20'sd13107);
		send_word(24'h20000, 24'h30000, 24'h10000, -20'sd65536);
		// Tolerance boundaries: b * 2^16 equals tol * a, then c * 2^16 equals tol * b, each also just above.
		send_word(24'h10000, 24'd66, 0, 20'sd32768);
		send_word(24'h10000, 24'd67, 0, 20'sd32768);
		send_word(24'h10000, 24'h8000, 24'd33, 20'sd32768);
		send_word(24'h10000, 24'h8000, 24'd34, 20'sd32768);
		drain();

		tol_plan = '{16'd66, 16'd0, 16'hFFFF, 16'($urandom), 16'd1000, 16'h5555};
		for (int blk = 0; blk < 6; blk++) begin
			write_tolerance(tol_plan[blk]);
			if (blk < 2) begin tx_idle = 10; rx_idle = 65; end
			else if (blk < 4) begin tx_idle = 65; rx_idle = 10; end
			else begin tx_idle = 0; rx_idle = 0; end
			for (int n = 0; n < 150; n++) send_random();
			drain();
		end

		if (sb.errors == 0 && sb.waiting.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/bpcd_pkg.sv
src/bpcd_fifo.sv
src/bpcd_mul.sv
src/bpcd_front.sv
src/bpcd_back.sv
src/box_plane_cut_distance.sv
tb/sv/tb_box_plane_cut_distance.sv
